[design/btks_pkg.sv]
// ----------------------------------------------------------------------------
// btks_pkg: shared types and constants of the byte trie key set
// Sizes of the node memory and the key, and the item structs of both channels.
// ----------------------------------------------------------------------------
package btks_pkg;

  // Key and trie geometry
  localparam int KEY_W     = 64;
  localparam int BYTE_W    = 8;
  localparam int KEY_BYTES = 8;
  localparam int MAX_NODES = 256;
  localparam int FANOUT    = 256;

  // Derived widths
  localparam int NODE_W  = $clog2(MAX_NODES);
  localparam int CNT_W   = $clog2(MAX_NODES + 1);
  localparam int ADDR_W  = NODE_W + BYTE_W;
  localparam int DEPTH   = MAX_NODES * FANOUT;
  localparam int LVL_W   = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1;

  // Request kinds
  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_QUERY  = 1'b1;

  typedef struct packed {
    logic             req_type;
    logic [KEY_W-1:0] key;
  } req_t;

  typedef struct packed {
    logic hit;
    logic full_res;
  } res_t;

endpackage

[design/byte_trie_exact_key_set.sv]
// ----------------------------------------------------------------------------
// byte_trie_exact_key_set: exact-match set of 8-byte keys in a byte trie
// Walks a 256-way trie held in a node memory, one key byte per level.
// ----------------------------------------------------------------------------
// After reset the block sweeps all MAX_NODES*256 entries (65536 at the default
// size) of its node memory to zero, one entry a cycle, with busy high. An
// item is then taken when start is high and busy low. Each trie level is a
// registered read from the single read port of the node memory: the entry
// read for one level gives the node address of the next. Busy stays high
// until the walk ends (queries stop at the first empty entry), so a new item
// is taken only after the last one is through. The result appears on out_res
// for exactly one cycle, flagged by out_valid, the cycle after the walk ends;
// it is never held back, and a new item may be taken while it is shown.
module byte_trie_exact_key_set (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  btks_pkg::req_t    in_req,
  output logic              out_valid,
  output btks_pkg::res_t    out_res
);

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_WALK  = 2'd2;

  // Node memory: entry zero means empty
  logic [btks_pkg::NODE_W-1:0] mem [btks_pkg::DEPTH];
  logic [btks_pkg::NODE_W-1:0] rdata_r;

  logic [1:0]                    state_r,   state_nxt;
  logic [btks_pkg::KEY_W-1:0]    key_r,     key_nxt;
  logic                          type_r,    type_nxt;
  logic [btks_pkg::LVL_W-1:0]    lvl_r,     lvl_nxt;
  logic [btks_pkg::CNT_W-1:0]    nf_r,      nf_nxt;
  logic [btks_pkg::ADDR_W-1:0]   clr_r,     clr_nxt;
  logic [btks_pkg::ADDR_W-1:0]   addr_r,    addr_nxt;
  logic                          vld_r,     vld_nxt;
  btks_pkg::res_t                res_r,     res_nxt;

  logic                          re;
  logic [btks_pkg::ADDR_W-1:0]   raddr;
  logic                          we;
  logic [btks_pkg::ADDR_W-1:0]   waddr;
  logic [btks_pkg::NODE_W-1:0]   wdata;
  logic                          empty;
  logic                          last;
  logic                          adv;
  logic [btks_pkg::NODE_W-1:0]   next_node;

  // Classify the entry read for the current level
  assign empty = (rdata_r == '0) ||
                 ({1'b0, rdata_r} >= (btks_pkg::NODE_W + 1)'(btks_pkg::MAX_NODES));
  assign last  = (lvl_r == btks_pkg::LVL_W'(btks_pkg::KEY_BYTES - 1));

  // Walk control
  always_comb begin
    state_nxt = state_r;
    key_nxt   = key_r;
    type_nxt  = type_r;
    lvl_nxt   = lvl_r;
    nf_nxt    = nf_r;
    clr_nxt   = clr_r;
    addr_nxt  = addr_r;
    vld_nxt   = 1'b0;
    res_nxt   = res_r;
    re        = 1'b0;
    raddr     = addr_r;
    we        = 1'b0;
    waddr     = addr_r;
    wdata     = '0;
    adv       = 1'b0;
    next_node = rdata_r;
    unique case (state_r)
      ST_CLEAR: begin
        we    = 1'b1;
        waddr = clr_r;
        if (clr_r == btks_pkg::ADDR_W'(btks_pkg::DEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end else begin
          clr_nxt = clr_r + 1'b1;
        end
      end
      ST_IDLE: begin
        if (start) begin
          type_nxt  = in_req.req_type;
          key_nxt   = in_req.key << btks_pkg::BYTE_W;
          lvl_nxt   = '0;
          raddr     = {{btks_pkg::NODE_W{1'b0}},
                       in_req.key[btks_pkg::KEY_W-1 -: btks_pkg::BYTE_W]};
          re        = 1'b1;
          addr_nxt  = raddr;
          state_nxt = ST_WALK;
        end
      end
      ST_WALK: begin
        if (type_r == btks_pkg::REQ_QUERY) begin
          if (empty || last) begin
            vld_nxt          = 1'b1;
            res_nxt.hit      = !empty;
            res_nxt.full_res = 1'b0;
            state_nxt        = ST_IDLE;
          end else begin
            adv = 1'b1;
          end
        end else begin
          if (last) begin
            // mark the key present
            we               = 1'b1;
            wdata            = btks_pkg::NODE_W'(1);
            vld_nxt          = 1'b1;
            res_nxt.hit      = 1'b0;
            res_nxt.full_res = 1'b0;
            state_nxt        = ST_IDLE;
          end else if (empty) begin
            if (nf_r == btks_pkg::CNT_W'(btks_pkg::MAX_NODES)) begin
              vld_nxt          = 1'b1;
              res_nxt.hit      = 1'b0;
              res_nxt.full_res = 1'b1;
              state_nxt        = ST_IDLE;
            end else begin
              // allocate a fresh node and link it in
              we        = 1'b1;
              wdata     = nf_r[btks_pkg::NODE_W-1:0];
              nf_nxt    = nf_r + 1'b1;
              next_node = nf_r[btks_pkg::NODE_W-1:0];
              adv       = 1'b1;
            end
          end else begin
            adv = 1'b1;
          end
        end
        // advance to the next level
        if (adv) begin
          raddr    = {next_node, key_r[btks_pkg::KEY_W-1 -: btks_pkg::BYTE_W]};
          re       = 1'b1;
          addr_nxt = raddr;
          key_nxt  = key_r << btks_pkg::BYTE_W;
          lvl_nxt  = lvl_r + 1'b1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      clr_r   <= '0;
      nf_r    <= btks_pkg::CNT_W'(1);
      vld_r   <= 1'b0;
      lvl_r   <= '0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      nf_r    <= nf_nxt;
      vld_r   <= vld_nxt;
      lvl_r   <= lvl_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    key_r  <= key_nxt;
    type_r <= type_nxt;
    addr_r <= addr_nxt;
    res_r  <= res_nxt;
  end

  // Node memory write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Node memory read port, registered
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = vld_r;
  assign out_res   = res_r;

endmodule

[design/btks_chk.sv]
// ----------------------------------------------------------------------------
// btks_chk: port-level checks of the byte trie key set
// Tracks the outstanding item and checks strobe and result rules over time.
// ----------------------------------------------------------------------------
module btks_chk (
  input logic           clk,
  input logic           rst_n,
  input logic           start,
  input logic           busy,
  input btks_pkg::req_t in_req,
  input logic           out_valid,
  input btks_pkg::res_t out_res
);

  logic pend_r;
  logic typ_r;
  logic acc;

  assign acc = start && !busy;

  // Track the item in flight and its kind
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 1'b0;
      typ_r  <= btks_pkg::REQ_INSERT;
    end else begin
      if (acc) begin
        pend_r <= 1'b1;
        typ_r  <= in_req.req_type;
      end else if (out_valid) begin
        pend_r <= 1'b0;
      end
    end
  end

  // An accepted item keeps the block busy in the next cycle
  a_acc_busy: assert property (@(posedge clk) disable iff (!rst_n)
    acc |=> busy) else $error("busy low right after an item was taken");

  // A result strobe lasts one cycle
  a_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result strobe held two cycles");

  // No result without an item in flight, and no second item while one is open
  a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid |-> pend_r) and (acc |-> (!pend_r || out_valid)))
    else $error("result and item count out of step");

  // Result flags agree with the kind of item
  a_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((typ_r == btks_pkg::REQ_QUERY) ? !out_res.full_res : !out_res.hit))
    else $error("result flag set for the wrong kind of item");

endmodule

bind byte_trie_exact_key_set btks_chk u_btks_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_req    (in_req),
  .out_valid (out_valid),
  .out_res   (out_res)
);

[sim/byte_trie_exact_key_set_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// byte_trie_exact_key_set_test: self-checking bench for the byte trie key set
// Sends insert and query items through the start/busy handshake. A local trie
// predicts every hit and full flag, and each strobed result is checked in
// order. Directed cases come first: extreme keys, a repeated insert, and
// misses that leave the path at each level. Random traffic follows, with
// shared prefixes, then node memory exhaustion, then more traffic once full.
// ----------------------------------------------------------------------------
module byte_trie_exact_key_set_test;

  localparam int LEAF_LVL    = btks_pkg::KEY_BYTES - 1;
  localparam int CYCLE_LIMIT = 400000;
  localparam int POOL_SIZE   = 16;
  localparam int KEEP_KEYS   = 1024;

  logic                       clk = 1'b0;
  logic                       rst_n;
  logic                       start;
  logic                       busy;
  btks_pkg::req_t             in_req;
  logic                       out_valid;
  btks_pkg::res_t             out_res;

  // Local copy of the trie: child links per node and byte, next free node
  bit [15:0]                  trie_links [btks_pkg::DEPTH];
  int unsigned                next_node = 1;
  bit                         mem_exhausted = 1'b0;

  btks_pkg::res_t             due_results [$];
  logic [btks_pkg::KEY_W-1:0] inserted_keys [$];
  logic [btks_pkg::KEY_W-1:0] prefix_pool [POOL_SIZE];
  int                         idle_pct = 31;
  int                         errors = 0;
  int unsigned                cycles = 0;

  byte_trie_exact_key_set u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_res   (out_res)
  );

  always #4 clk = ~clk;

  // Abort a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, cycles);
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic int unsigned key_byte(logic [btks_pkg::KEY_W-1:0] k, int lvl);
    return 32'(k[btks_pkg::KEY_W-1-btks_pkg::BYTE_W*lvl -: btks_pkg::BYTE_W]);
  endfunction

  // Walk the local trie for one item; inserts grow it and may run out of nodes
  function automatic btks_pkg::res_t walk_trie(btks_pkg::req_t r);
    btks_pkg::res_t res;
    int unsigned    node;
    int unsigned    slot;
    int unsigned    link;
    res  = '0;
    node = 0;
    for (int lvl = 0; lvl < btks_pkg::KEY_BYTES; lvl++) begin
      if (node >= btks_pkg::MAX_NODES) return res;
      slot = node * btks_pkg::FANOUT + key_byte(r.key, lvl);
      link = 32'(trie_links[slot]);
      if (r.req_type == btks_pkg::REQ_QUERY) begin
        if (link == 0) return res;
        if (lvl == LEAF_LVL) begin
          res.hit = 1'b1;
          return res;
        end
      end else begin
        if (lvl == LEAF_LVL) begin
          trie_links[slot] = 16'd1;
          return res;
        end
        if (link == 0 || link >= btks_pkg::MAX_NODES) begin
          if (next_node >= btks_pkg::MAX_NODES) begin
            res.full_res  = 1'b1;
            mem_exhausted = 1'b1;
            return res;
          end
          link = next_node;
          next_node++;
          trie_links[slot] = link[15:0];
        end
      end
      node = link;
    end
    return res;
  endfunction

  function automatic logic [btks_pkg::KEY_W-1:0] rand_key();
    return {$urandom, $urandom};
  endfunction

  // Key on one of the shared prefixes with a random last byte
  function automatic logic [btks_pkg::KEY_W-1:0] pool_key();
    logic [btks_pkg::KEY_W-1:0] k;
    k = prefix_pool[$urandom_range(POOL_SIZE-1)];
    k[btks_pkg::BYTE_W-1:0] = btks_pkg::BYTE_W'($urandom);
    return k;
  endfunction

  // Earlier key with one byte changed, so the walk leaves the path somewhere
  function automatic logic [btks_pkg::KEY_W-1:0] near_key(logic [btks_pkg::KEY_W-1:0] k);
    logic [btks_pkg::KEY_W-1:0] flip;
    flip = btks_pkg::KEY_W'(btks_pkg::BYTE_W'($urandom_range(1, 255)));
    return k ^ (flip << (btks_pkg::BYTE_W * $urandom_range(0, btks_pkg::KEY_BYTES-1)));
  endfunction

  // Offer one item, hold it until taken, and queue its predicted result
  task automatic send_item(logic kind, logic [btks_pkg::KEY_W-1:0] k);
    btks_pkg::req_t r;
    bit             taken;
    r.req_type = kind;
    r.key      = k;
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_req <= r;
    start  <= 1'b1;
    do begin
      @(negedge clk);
      taken = (busy === 1'b0);
      @(posedge clk);
    end while (!taken);
    due_results = {due_results, walk_trie(r)};
    if (kind == btks_pkg::REQ_INSERT && inserted_keys.size() < KEEP_KEYS)
      inserted_keys = {inserted_keys, k};
  endtask

  // Check each strobed result against the oldest prediction
  always @(negedge clk) begin : check_results
    btks_pkg::res_t want;
    if (rst_n === 1'b1 && out_valid === 1'b1) begin
      if (due_results.size() == 0) begin
        $display("%0t: unexpected result, got hit=%b full_res=%b",
                 $time, out_res.hit, out_res.full_res);
        errors++;
      end else begin
        want = due_results.pop_front();
        if (out_res.hit !== want.hit) begin
          $display("%0t: hit mismatch, expected %b, got %b", $time, want.hit, out_res.hit);
          errors++;
        end
        if (out_res.full_res !== want.full_res) begin
          $display("%0t: full_res mismatch, expected %b, got %b",
                   $time, want.full_res, out_res.full_res);
          errors++;
        end
      end
    end
  end

  // Empty set, all-zero and all-one keys, alternating bit patterns
  task automatic test_extreme_keys();
    send_item(btks_pkg::REQ_QUERY,  '0);
    send_item(btks_pkg::REQ_QUERY,  '1);
    send_item(btks_pkg::REQ_INSERT, '0);
    send_item(btks_pkg::REQ_INSERT, '1);
    send_item(btks_pkg::REQ_QUERY,  '0);
    send_item(btks_pkg::REQ_QUERY,  '1);
    send_item(btks_pkg::REQ_QUERY,  btks_pkg::KEY_W'(1));
    send_item(btks_pkg::REQ_QUERY,  btks_pkg::KEY_W'(1) << (btks_pkg::KEY_W-1));
    send_item(btks_pkg::REQ_INSERT, {(btks_pkg::KEY_W/2){2'b10}});
    send_item(btks_pkg::REQ_QUERY,  {(btks_pkg::KEY_W/2){2'b01}});
  endtask

  // Insert the same key twice; the second must change nothing
  task automatic test_duplicate_insert();
    send_item(btks_pkg::REQ_INSERT, 64'h0123_4567_89AB_CDEF);
    send_item(btks_pkg::REQ_INSERT, 64'h0123_4567_89AB_CDEF);
    send_item(btks_pkg::REQ_QUERY,  64'h0123_4567_89AB_CDEF);
  endtask

  // Misses that leave a stored path at every level, then a last-byte sibling
  task automatic test_divergent_paths();
    logic [btks_pkg::KEY_W-1:0] k;
    k = 64'h0123_4567_89AB_CDEF;
    for (int lvl = 0; lvl < btks_pkg::KEY_BYTES; lvl++)
      send_item(btks_pkg::REQ_QUERY,
                k ^ (btks_pkg::KEY_W'(8'hFF) << (btks_pkg::BYTE_W * lvl)));
    send_item(btks_pkg::REQ_INSERT, k ^ btks_pkg::KEY_W'(8'h01));
    send_item(btks_pkg::REQ_QUERY,  k ^ btks_pkg::KEY_W'(8'h01));
  endtask

  // Mixed traffic, mostly on shared prefixes; one long stretch without gaps
  task automatic test_random_traffic(int n);
    int sel;
    for (int i = 0; i < n; i++) begin
      idle_pct = (i >= n/3 && i < n/3 + 150) ? 0 : 31;
      sel = $urandom_range(99);
      if (sel < 40)
        send_item(btks_pkg::REQ_INSERT, pool_key());
      else if (sel < 48)
        send_item(btks_pkg::REQ_INSERT, rand_key());
      else if (sel < 75)
        send_item(btks_pkg::REQ_QUERY,
                  inserted_keys[$urandom_range(inserted_keys.size()-1)]);
      else if (sel < 88)
        send_item(btks_pkg::REQ_QUERY, pool_key());
      else if (sel < 94)
        send_item(btks_pkg::REQ_QUERY,
                  near_key(inserted_keys[$urandom_range(inserted_keys.size()-1)]));
      else
        send_item(btks_pkg::REQ_QUERY, rand_key());
    end
    idle_pct = 31;
  endtask

  // Run the node memory dry, then check inserts with and without new nodes
  task automatic test_memory_exhaustion();
    logic [btks_pkg::KEY_W-1:0] k;
    while (!mem_exhausted)
      send_item(btks_pkg::REQ_INSERT, rand_key());
    // an existing prefix needs no node, so this still succeeds
    k = prefix_pool[0];
    k[btks_pkg::BYTE_W-1:0] = btks_pkg::BYTE_W'($urandom);
    send_item(btks_pkg::REQ_INSERT, k);
    send_item(btks_pkg::REQ_QUERY,  k);
    // fresh path: refused, and the key stays absent
    k = rand_key();
    send_item(btks_pkg::REQ_INSERT, k);
    send_item(btks_pkg::REQ_QUERY,  k);
    send_item(btks_pkg::REQ_INSERT, inserted_keys[0]);
    send_item(btks_pkg::REQ_QUERY,  inserted_keys[0]);
  endtask

  initial begin
    logic [btks_pkg::KEY_W-1:0] base;
    int                         split;
    rst_n  <= 1'b0;
    start  <= 1'b0;
    in_req <= '0;
    // prefixes share a random stem and part ways at random levels
    base = rand_key();
    foreach (prefix_pool[p]) begin
      prefix_pool[p] = base;
      split = $urandom_range(0, btks_pkg::KEY_BYTES-2);
      for (int j = split; j < btks_pkg::KEY_BYTES; j++)
        prefix_pool[p][btks_pkg::KEY_W-1-btks_pkg::BYTE_W*j -: btks_pkg::BYTE_W] =
          btks_pkg::BYTE_W'($urandom);
    end
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    test_extreme_keys();
    test_duplicate_insert();
    test_divergent_paths();
    test_random_traffic(400);
    test_memory_exhaustion();
    test_random_traffic(410);

    // drain outstanding results, then allow for a late stray one
    start <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (btks_pkg::KEY_BYTES + 4) @(posedge clk);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
